// ===== rtl/ftto_pkg.sv =====
// Shared constants, tables and types for the frequency to table offset unit.
// Used by every module under rtl; depends on nothing.
package ftto_pkg;

  localparam int TABLE_BANDS  = 5;
  localparam int RECORD_BYTES = 6;
  localparam int BAND_COUNT   = 5;

  localparam int FREQ_W  = 16;
  localparam int BAND_W  = 3;
  localparam int OFF_W   = 14;
  localparam int PROD_W  = 30;
  localparam int QUOT_W  = 12;
  localparam int TOTAL_W = 13;
  localparam int RB_W    = 7;

  // floor(x / 5) == (x * RECIP_5) >> RECIP_SHIFT for x below 2**OFF_W
  localparam logic [15:0] RECIP_5     = 16'd52429;
  localparam int          RECIP_SHIFT = 18;

  localparam logic [FREQ_W-1:0] BAND_START_X10 [0:TABLE_BANDS] =
    '{16'd1500, 16'd3000, 16'd6000, 16'd12000, 16'd24000, 16'd30000};

  // band step is 5 shifted left by this amount
  localparam logic [2:0] BAND_STEP_SHIFT [0:TABLE_BANDS-1] =
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

  // running sum of the point counts of all lower bands
  localparam logic [10:0] POINTS_BEFORE [0:TABLE_BANDS] =
    '{11'd0, 11'd300, 11'd600, 11'd900, 11'd1200, 11'd1275};

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  scaled;
    logic              below;
    logic              above;
  } band_info_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               below;
    logic               above;
  } point_count_t;

  function automatic int eff_bands(input int n);
    return (n > TABLE_BANDS) ? TABLE_BANDS : n;
  endfunction

endpackage

// ===== rtl/ftto_digit_sum.sv =====
// Stage 1: weights the five digit nibbles and sums them into a 16-bit frequency.
// Depends on ftto_pkg.
module ftto_digit_sum (
  input  logic                        clk,
  input  logic                        en,
  input  logic [3:0]                  digit_ten_thousands,
  input  logic [3:0]                  digit_thousands,
  input  logic [3:0]                  digit_hundreds,
  input  logic [3:0]                  digit_tens,
  input  logic [3:0]                  digit_ones,
  output logic [ftto_pkg::FREQ_W-1:0] freq_r
);

  logic [17:0]                  sum;
  logic [ftto_pkg::FREQ_W-1:0]  freq_nxt;

  always_comb begin
    sum = 18'(digit_ten_thousands) * 18'd10000
        + 18'(digit_thousands)     * 18'd1000
        + 18'(digit_hundreds)      * 18'd100
        + 18'(digit_tens)          * 18'd10
        + 18'(digit_ones);
    freq_nxt = sum[ftto_pkg::FREQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      freq_r <= freq_nxt;
    end
  end

endmodule

// ===== rtl/ftto_band_sel.sv =====
// Stage 2: finds the band, the offset into it and the range flags.
// Depends on ftto_pkg.
module ftto_band_sel #(
  parameter int BAND_COUNT = ftto_pkg::BAND_COUNT
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ftto_pkg::FREQ_W-1:0] freq,
  output ftto_pkg::band_info_t        info_r
);

  localparam int NB = ftto_pkg::eff_bands(BAND_COUNT);

  ftto_pkg::band_info_t              info_nxt;
  logic [ftto_pkg::BAND_W-1:0]       band;
  logic                              found;
  logic [ftto_pkg::FREQ_W-1:0]       diff;

  always_comb begin
    band  = '0;
    found = 1'b0;
    for (int i = 0; i < ftto_pkg::TABLE_BANDS; i++) begin
      if ((i < NB) && (freq > ftto_pkg::BAND_START_X10[i])) begin
        band  = ftto_pkg::BAND_W'(i);
        found = 1'b1;
      end
    end
    diff            = freq - ftto_pkg::BAND_START_X10[band];
    info_nxt.band   = band;
    info_nxt.off    = diff[ftto_pkg::OFF_W-1:0];
    info_nxt.scaled = diff[ftto_pkg::OFF_W-1:0] >> ftto_pkg::BAND_STEP_SHIFT[band];
    info_nxt.below  = !found;
    info_nxt.above  = freq > ftto_pkg::BAND_START_X10[NB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info_r <= info_nxt;
    end
  end

endmodule

// ===== rtl/ftto_point_div.sv =====
// Stages 3 and 4: divides the offset by the band step with rounding and adds the
// point counts of the lower bands. Depends on ftto_pkg.
module ftto_point_div (
  input  logic                  clk,
  input  logic                  en_mul,
  input  logic                  en_sum,
  input  ftto_pkg::band_info_t  info,
  output ftto_pkg::point_count_t count_r
);

  logic [ftto_pkg::PROD_W-1:0]  prod_r;
  logic [ftto_pkg::PROD_W-1:0]  prod_nxt;
  ftto_pkg::band_info_t         info_r;
  ftto_pkg::point_count_t       count_nxt;
  logic [ftto_pkg::QUOT_W-1:0]  quot;
  logic [2:0]                   shift;
  logic [6:0]                   step;
  logic [18:0]                  qstep;
  logic [15:0]                  rem;
  logic                         round_up;

  assign prod_nxt = ftto_pkg::PROD_W'(info.scaled) * ftto_pkg::PROD_W'(ftto_pkg::RECIP_5);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= prod_nxt;
      info_r <= info;
    end
  end

  always_comb begin
    quot     = prod_r[ftto_pkg::PROD_W-1:ftto_pkg::RECIP_SHIFT];
    shift    = ftto_pkg::BAND_STEP_SHIFT[info_r.band];
    step     = 7'd5 << shift;
    qstep    = (19'(quot) * 19'd5) << shift;
    rem      = 16'(info_r.off) - qstep[15:0];
    round_up = rem >= 16'(step >> 1);
    count_nxt.total = ftto_pkg::TOTAL_W'(ftto_pkg::POINTS_BEFORE[info_r.band])
                    + ftto_pkg::TOTAL_W'(quot)
                    + ftto_pkg::TOTAL_W'(round_up);
    count_nxt.below = info_r.below;
    count_nxt.above = info_r.above;
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/frequency_to_table_offset_unit.sv =====
// Top level of the frequency to table offset unit: five-stage pipeline with
// valid tracking and per-stage stall. Depends on ftto_pkg, ftto_digit_sum,
// ftto_band_sel and ftto_point_div.
//
// Usage:
//   The input channel carries five decimal digit nibbles (in_digit_*). A
//   transaction completes on a rising edge with in_valid high and in_stall low.
//   The result channel carries out_byte_offset, out_below_range and
//   out_above_range; a transaction completes with out_valid high and out_stall
//   low. Each input transaction gives exactly one result, in order.
//   Throughput is one transaction per cycle while out_stall is low; the stages
//   are digit sum, band select, reciprocal multiply, rounding and point sum,
//   and record scaling. A stall on the result side holds the output register;
//   upstream stages keep filling empty slots, and in_stall rises only once
//   every stage holds a transaction. Reset (rst_n low, synchronous) clears all
//   valid bits; no transaction is in flight after it.
module frequency_to_table_offset_unit #(
  parameter int RECORD_BYTES = ftto_pkg::RECORD_BYTES,
  parameter int BAND_COUNT   = ftto_pkg::BAND_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_digit_ten_thousands,
  input  logic [3:0]  in_digit_thousands,
  input  logic [3:0]  in_digit_hundreds,
  input  logic [3:0]  in_digit_tens,
  input  logic [3:0]  in_digit_ones,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_byte_offset,
  output logic        out_below_range,
  output logic        out_above_range
);

  localparam int                        NB = ftto_pkg::eff_bands(BAND_COUNT);
  localparam logic [ftto_pkg::RB_W-1:0] RB = ftto_pkg::RB_W'(RECORD_BYTES);
  localparam logic [15:0] ABOVE_TOTAL = 16'(ftto_pkg::POINTS_BEFORE[NB]);

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en5;

  logic [ftto_pkg::FREQ_W-1:0]  freq;
  ftto_pkg::band_info_t         info;
  ftto_pkg::point_count_t       count;

  logic [19:0] scaled;
  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic        below_r, above_r;

  assign en5 = !out_valid_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r        <= in_valid;
      if (en2) v2_r        <= v1_r;
      if (en3) v3_r        <= v2_r;
      if (en4) v4_r        <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  ftto_digit_sum u_digit_sum (
    .clk                 (clk),
    .en                  (en1),
    .digit_ten_thousands (in_digit_ten_thousands),
    .digit_thousands     (in_digit_thousands),
    .digit_hundreds      (in_digit_hundreds),
    .digit_tens          (in_digit_tens),
    .digit_ones          (in_digit_ones),
    .freq_r              (freq)
  );

  ftto_band_sel #(
    .BAND_COUNT (BAND_COUNT)
  ) u_band_sel (
    .clk    (clk),
    .en     (en2),
    .freq   (freq),
    .info_r (info)
  );

  ftto_point_div u_point_div (
    .clk     (clk),
    .en_mul  (en3),
    .en_sum  (en4),
    .info    (info),
    .count_r (count)
  );

  always_comb begin
    scaled = 20'(count.total) * 20'(RB);
    if (count.above) begin
      byte_offset_nxt = ABOVE_TOTAL;
    end else if (count.below) begin
      byte_offset_nxt = '0;
    end else begin
      byte_offset_nxt = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      byte_offset_r <= byte_offset_nxt;
      below_r       <= count.below && !count.above;
      above_r       <= count.above;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_offset = byte_offset_r;
  assign out_below_range = below_r;
  assign out_above_range = above_r;

endmodule

// ===== sim/tb_frequency_to_table_offset_unit.sv =====
// Self-checking testbench for frequency_to_table_offset_unit: directed readings, then random ones,
// with random idling on both channels, each result checked against a listed value or an in-bench
// predictor. Depends only on the RTL under rtl/.
module tb_frequency_to_table_offset_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RECORD_BYTES = 6;
  localparam int BAND_COUNT = 5;
  localparam int ACTIVE_BANDS = (BAND_COUNT > 5) ? 5 : BAND_COUNT;
  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_ITEMS = 1500;
  localparam int LONG_HOLD = 48;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam int unsigned CAL_START_X10 [0:5] = '{1500, 3000, 6000, 12000, 24000, 30000};
  localparam int unsigned CAL_STEP [0:5] = '{5, 10, 20, 40, 80, 100};
  localparam int unsigned CAL_POINTS [0:5] = '{300, 300, 300, 300, 75, 0};

  typedef struct packed {
    logic [3:0] ten_thousands;
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } reading_t;

  typedef struct packed {
    logic [15:0] byte_offset;
    logic        below_range;
    logic        above_range;
  } table_ref_t;

  typedef struct packed {
    logic [3:0]  ten_thousands;
    logic [3:0]  thousands;
    logic [3:0]  hundreds;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic        typed;
    logic [15:0] byte_offset;
    logic        below_range;
    logic        above_range;
  } directed_row_t;

  localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 16'd0,    1'b1, 1'b0},
    '{4'd0,  4'd1,  4'd5,  4'd0,  4'd0,  1'b1, 16'd0,    1'b1, 1'b0},
    '{4'd0,  4'd1,  4'd5,  4'd0,  4'd1,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd1,  4'd5,  4'd0,  4'd2,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd1,  4'd5,  4'd0,  4'd4,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd2,  4'd9,  4'd9,  4'd9,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd3,  4'd0,  4'd0,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd3,  4'd0,  4'd0,  4'd5,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd5,  4'd9,  4'd9,  4'd9,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd6,  4'd0,  4'd1,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd1,  4'd2,  4'd0,  4'd0,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd1,  4'd2,  4'd0,  4'd2,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd2,  4'd4,  4'd0,  4'd0,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd2,  4'd4,  4'd0,  4'd4,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd2,  4'd9,  4'd9,  4'd9,  4'd9,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd3,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd3,  4'd0,  4'd0,  4'd0,  4'd1,  1'b1, 16'd1275, 1'b0, 1'b1},
    '{4'd6,  4'd5,  4'd5,  4'd3,  4'd5,  1'b1, 16'd1275, 1'b0, 1'b1},
    '{4'd6,  4'd5,  4'd5,  4'd3,  4'd6,  1'b1, 16'd0,    1'b1, 1'b0},
    '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 16'd1275, 1'b0, 1'b1},
    '{4'd0,  4'd0,  4'd15, 4'd15, 4'd15, 1'b0, 16'd0,    1'b0, 1'b0},
    '{4'd0,  4'd0,  4'd0,  4'd15, 4'd15, 1'b1, 16'd0,    1'b1, 1'b0},
    '{4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  1'b1, 16'd1275, 1'b0, 1'b1},
    '{4'd7,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 16'd0,    1'b0, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_digit_ten_thousands;
  logic [3:0]  in_digit_thousands;
  logic [3:0]  in_digit_hundreds;
  logic [3:0]  in_digit_tens;
  logic [3:0]  in_digit_ones;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_byte_offset;
  logic        out_below_range;
  logic        out_above_range;

  table_ref_t offsets_due [$];
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int below_count = 0;
  int above_count = 0;
  int idle_cycles = 0;
  bit idle_enable = 1'b1;
  bit quiet_tail = 1'b0;
  bit hold_request = 1'b0;
  bit hold_active = 1'b0;

  frequency_to_table_offset_unit #(
    .RECORD_BYTES(RECORD_BYTES),
    .BAND_COUNT(BAND_COUNT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_digit_ten_thousands(in_digit_ten_thousands),
    .in_digit_thousands(in_digit_thousands),
    .in_digit_hundreds(in_digit_hundreds),
    .in_digit_tens(in_digit_tens),
    .in_digit_ones(in_digit_ones),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte_offset(out_byte_offset),
    .out_below_range(out_below_range),
    .out_above_range(out_above_range)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic table_ref_t predict_table_ref(input reading_t r);
    table_ref_t res;
    int unsigned freq;
    int unsigned off;
    int unsigned total;
    int band;
    res = '0;
    band = -1;
    total = 0;
    freq = (r.ten_thousands * 10000 + r.thousands * 1000 + r.hundreds * 100
            + r.tens * 10 + r.ones) % 65536;
    if (freq > CAL_START_X10[ACTIVE_BANDS]) begin
      for (int b = 0; b < ACTIVE_BANDS; b++) total += CAL_POINTS[b];
      res.byte_offset = 16'(total);
      res.above_range = 1'b1;
      return res;
    end
    for (int b = 0; b < ACTIVE_BANDS; b++) begin
      if (freq > CAL_START_X10[b]) band = b;
    end
    if (band < 0) begin
      res.below_range = 1'b1;
      return res;
    end
    off = freq - CAL_START_X10[band];
    total = off / CAL_STEP[band];
    if (off % CAL_STEP[band] >= CAL_STEP[band] / 2) total += 1;
    for (int b = 0; b < band; b++) total += CAL_POINTS[b];
    res.byte_offset = 16'(total * RECORD_BYTES);
    return res;
  endfunction

  function automatic reading_t random_reading();
    reading_t r;
    int f;
    case ($urandom_range(0, 3))
      0: r = reading_t'($urandom);
      1: r = '{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
               4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: begin
        // land near a band edge
        f = int'(CAL_START_X10[$urandom_range(0, 5)]) + int'($urandom_range(0, 220)) - 110;
        r = '{4'(f / 10000), 4'((f / 1000) % 10), 4'((f / 100) % 10), 4'((f / 10) % 10),
              4'(f % 10)};
      end
    endcase
    return r;
  endfunction

  task automatic send_reading(input reading_t r, input table_ref_t want);
    in_valid <= 1'b1;
    in_digit_ten_thousands <= r.ten_thousands;
    in_digit_thousands <= r.thousands;
    in_digit_hundreds <= r.hundreds;
    in_digit_tens <= r.tens;
    in_digit_ones <= r.ones;
    do @(posedge clk); while (in_stall);
    offsets_due.push_back(want);
    sent_count++;
  endtask

  task automatic maybe_pause();
    if (idle_enable && !quiet_tail && !hold_request && !hold_active
        && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    reading_t r;
    table_ref_t want;
    in_valid = 1'b0;
    in_digit_ten_thousands = '0;
    in_digit_thousands = '0;
    in_digit_hundreds = '0;
    in_digit_tens = '0;
    in_digit_ones = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      r = '{DIRECTED[i].ten_thousands, DIRECTED[i].thousands, DIRECTED[i].hundreds,
            DIRECTED[i].tens, DIRECTED[i].ones};
      if (DIRECTED[i].typed)
        want = '{DIRECTED[i].byte_offset, DIRECTED[i].below_range, DIRECTED[i].above_range};
      else
        want = predict_table_ref(r);
      maybe_pause();
      send_reading(r, want);
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      if (k == RANDOM_ITEMS - 150) quiet_tail = 1'b1;
      if (k == 300) hold_request = 1'b1;
      if (k == 700) begin
        // drain everything before going on
        in_valid <= 1'b0;
        do @(posedge clk); while (offsets_due.size() != 0);
      end
      maybe_pause();
      r = random_reading();
      send_reading(r, predict_table_ref(r));
    end

    in_valid <= 1'b0;
    while (offsets_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d readings (%0d directed), %0d results checked: %0d below range, %0d above.",
             sent_count, DIRECTED_ROWS, checked_count, below_count, above_count);
    $display("Both channels idled in random bursts, with one long result hold-off and one drain.");
    if (error_count == 0) begin
      $display("frequency_to_table_offset_unit regression: pass");
    end else begin
      $display("frequency_to_table_offset_unit regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_active = 1'b0;
      end else if (idle_enable && !quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    table_ref_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (out_below_range) below_count++;
      if (out_above_range) above_count++;
      if (offsets_due.size() == 0) begin
        $display("%0t: result with nothing outstanding: offset %0d below %0b above %0b",
                 $time, out_byte_offset, out_below_range, out_above_range);
        error_count++;
      end else begin
        want = offsets_due.pop_front();
        if (out_byte_offset !== want.byte_offset) begin
          $display("%0t: byte_offset expected %0d actual %0d", $time, want.byte_offset,
                   out_byte_offset);
          error_count++;
        end
        if (out_below_range !== want.below_range) begin
          $display("%0t: below_range expected %0b actual %0b", $time, want.below_range,
                   out_below_range);
          error_count++;
        end
        if (out_above_range !== want.above_range) begin
          $display("%0t: above_range expected %0b actual %0b", $time, want.above_range,
                   out_above_range);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, offsets_due.size());
        $display("frequency_to_table_offset_unit regression: fail");
        $finish;
      end
    end
  end

endmodule
